/* hw/rtl/vertex_normal_accumulator_defines.svh */
// assertion macros for the vertex normal accumulator
`ifndef VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define VNA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define VNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/vna_pkg.sv */
// shared types, constants and helpers of the vertex normal accumulator
package vna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_WIDTH    = 10;
  localparam int COORD_WIDTH  = 16;
  localparam int SUM_WIDTH    = 48;

  // exact widths of the cross product path
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NRM_W  = PROD_W + 1;

  localparam logic [1:0] OP_WRITE_VERTEX = 2'd0;
  localparam logic [1:0] OP_FACE         = 2'd1;
  localparam logic [1:0] OP_READ         = 2'd2;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                    op;
    logic [IDX_WIDTH-1:0]          vertex_index;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic [IDX_WIDTH-1:0]          corner_a;
    logic [IDX_WIDTH-1:0]          corner_b;
    logic [IDX_WIDTH-1:0]          corner_c;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] normal_x;
    logic signed [SUM_WIDTH-1:0] normal_y;
    logic signed [SUM_WIDTH-1:0] normal_z;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] x;
    logic signed [SUM_WIDTH-1:0] y;
    logic signed [SUM_WIDTH-1:0] z;
  } sum_vec_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } nrm_vec_t;

  // strobes from the sequencer to the cross product unit
  typedef struct packed {
    logic load_v0;
    logic load_v1;
    logic load_v2;   // also starts the multiply sequence
  } xp_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VRD_A,
    ST_VRD_B,
    ST_VRD_C,
    ST_VLD_C,
    ST_MUL,
    ST_SRD,
    ST_SWR,
    ST_RRD,
    ST_RWAIT
  } state_e;

  function automatic logic idx_ok(input logic [IDX_WIDTH-1:0] idx);
    return 32'(idx) < MAX_VERTICES;
  endfunction

  // one saturating addition of a normal component into a sum
  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] s,
    input logic signed [NRM_W-1:0]     n
  );
    logic signed [SUM_WIDTH:0] t;
    t = $signed({s[SUM_WIDTH-1], s})
      + $signed({{(SUM_WIDTH+1-NRM_W){n[NRM_W-1]}}, n});
    if (t[SUM_WIDTH] != t[SUM_WIDTH-1]) begin
      return t[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end
    return t[SUM_WIDTH-1:0];
  endfunction

endpackage

/* hw/rtl/vertex_normal_accumulator.sv */
// top level of the vertex normal accumulator: sequencer, memories, result register
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid / in_ready  | vna_pkg::in_word_t
//   out     | output    | out_valid / out_ready| vna_pkg::out_word_t
//
// write vertex is done in its accept cycle; read vertex reads the sum ram, then waits out any output stall;
// accumulate face: the accept cycle, 3 vertex ram reads and a load cycle,
// the multiply sequence on the one shared multiplier, then a read-modify-write of the sum ram for each
// corner, a read state and then a write state
// reset (rst_n low, synchronous) clears the sequencer, the multiply sequence and the result valid only;
// ram contents are undefined until a vertex is written
// in_ready is high only when the sequencer is idle; a finished read waits in
// its own state while an earlier result is still held in the output register
`include "vertex_normal_accumulator_defines.svh"

module vertex_normal_accumulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vna_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vna_pkg::out_word_t out_data
);
  import vna_pkg::*;

  state_e               state_r, state_nxt;
  logic [1:0]           crn_r, crn_nxt;
  logic [IDX_WIDTH-1:0] ca_r, cb_r, cc_r;
  logic [IDX_WIDTH-1:0] rd_idx_r;
  logic                 rd_ok_r;
  logic                 out_valid_r;
  out_word_t            out_data_r;

  logic                 accept;
  logic                 face_ok;
  logic                 out_load;
  logic [IDX_WIDTH-1:0] crn_idx;

  // vertex ram port
  logic                 v_we, v_re;
  logic [IDX_WIDTH-1:0] v_addr;
  vtx_t                 v_wdata, v_rdata;

  // sum ram port
  logic                 s_we, s_re;
  logic [IDX_WIDTH-1:0] s_addr;
  sum_vec_t             s_wdata, s_rdata;

  xp_ctl_t              xp_ctl;
  logic                 xp_done;
  nrm_vec_t             nrm;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign face_ok   = idx_ok(in_data.corner_a) && idx_ok(in_data.corner_b)
                  && idx_ok(in_data.corner_c);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // corner whose sums are being updated
  always_comb begin
    case (crn_r)
      2'd0:    crn_idx = ca_r;
      2'd1:    crn_idx = cb_r;
      default: crn_idx = cc_r;
    endcase
  end

  // sequencer: next state and port controls
  always_comb begin
    state_nxt = state_r;
    crn_nxt   = crn_r;
    v_we      = 1'b0;
    v_re      = 1'b0;
    v_addr    = ca_r;
    v_wdata   = '{x: in_data.coord_x, y: in_data.coord_y, z: in_data.coord_z};
    s_we      = 1'b0;
    s_re      = 1'b0;
    s_addr    = crn_idx;
    s_wdata   = '{x: sat_add(s_rdata.x, nrm.x), y: sat_add(s_rdata.y, nrm.y),
                  z: sat_add(s_rdata.z, nrm.z)};
    xp_ctl    = '0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.op)
            OP_WRITE_VERTEX: begin
              // store coordinates and clear the sums in the same cycle
              v_we    = idx_ok(in_data.vertex_index);
              v_addr  = in_data.vertex_index;
              s_we    = idx_ok(in_data.vertex_index);
              s_addr  = in_data.vertex_index;
              s_wdata = '0;
            end
            OP_FACE: begin
              if (face_ok) begin
                state_nxt = ST_VRD_A;
              end
            end
            OP_READ: begin
              state_nxt = ST_RRD;
            end
            default: ;
          endcase
        end
      end
      ST_VRD_A: begin
        v_re      = 1'b1;
        v_addr    = ca_r;
        state_nxt = ST_VRD_B;
      end
      ST_VRD_B: begin
        v_re           = 1'b1;
        v_addr         = cb_r;
        xp_ctl.load_v0 = 1'b1;
        state_nxt      = ST_VRD_C;
      end
      ST_VRD_C: begin
        v_re           = 1'b1;
        v_addr         = cc_r;
        xp_ctl.load_v1 = 1'b1;
        state_nxt      = ST_VLD_C;
      end
      ST_VLD_C: begin
        xp_ctl.load_v2 = 1'b1;
        state_nxt      = ST_MUL;
      end
      ST_MUL: begin
        if (xp_done) begin
          crn_nxt   = 2'd0;
          state_nxt = ST_SRD;
        end
      end
      ST_SRD: begin
        s_re      = 1'b1;
        state_nxt = ST_SWR;
      end
      ST_SWR: begin
        // repeated corners read the sum that the previous corner's write state stored
        s_we = 1'b1;
        if (crn_r == 2'd2) begin
          state_nxt = ST_IDLE;
        end else begin
          crn_nxt   = crn_r + 2'd1;
          state_nxt = ST_SRD;
        end
      end
      ST_RRD: begin
        s_re      = 1'b1;
        s_addr    = rd_idx_r;
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        s_addr = rd_idx_r;
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      crn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      crn_r   <= crn_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload latches
  always_ff @(posedge clk) begin
    if (accept) begin
      ca_r     <= in_data.corner_a;
      cb_r     <= in_data.corner_b;
      cc_r     <= in_data.corner_c;
      rd_idx_r <= in_data.vertex_index;
      rd_ok_r  <= idx_ok(in_data.vertex_index);
    end
    if (out_load) begin
      out_data_r <= rd_ok_r ? out_word_t'{normal_x: s_rdata.x, normal_y: s_rdata.y,
                                          normal_z: s_rdata.z} : out_word_t'('0);
    end
  end

  vna_ram #(
    .DATA_W ($bits(vtx_t)),
    .DEPTH  (MAX_VERTICES)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (v_we),
    .re    (v_re),
    .addr  (v_addr),
    .wdata (v_wdata),
    .rdata (v_rdata)
  );

  vna_ram #(
    .DATA_W ($bits(sum_vec_t)),
    .DEPTH  (MAX_VERTICES)
  ) u_sum_ram (
    .clk   (clk),
    .we    (s_we),
    .re    (s_re),
    .addr  (s_addr),
    .wdata (s_wdata),
    .rdata (s_rdata)
  );

  vna_cross_unit u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (xp_ctl),
    .vdata (v_rdata),
    .done  (xp_done),
    .nrm   (nrm)
  );

  // single-port sum ram never reads and writes together
  `VNA_ASSERT_NOW(a_sum_port_excl, s_we, !s_re, "sum ram read and write in one cycle")
  // multiply sequence only finishes while the sequencer waits for it
  `VNA_ASSERT_NOW(a_done_in_mul, xp_done, state_r == ST_MUL, "cross product done outside mul")
  // a face updates all three corners before going idle
  `VNA_ASSERT_NEXT(a_three_corners, (state_r == ST_SWR) && (crn_r != 2'd2),
                   state_r == ST_SRD, "face left before third corner")
  // an in-range face starts its vertex reads right away
  `VNA_ASSERT_NEXT(a_face_start, accept && (in_data.op == OP_FACE) && face_ok,
                   state_r == ST_VRD_A, "accepted face did not start")

endmodule

/* hw/rtl/vna_ram.sv */
// generic single-port ram with registered read
module vna_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* hw/rtl/vna_cross_unit.sv */
// edge vectors and cross product through one shared multiplier
module vna_cross_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  vna_pkg::xp_ctl_t ctl,
  input  vna_pkg::vtx_t    vdata,
  output logic             done,
  output vna_pkg::nrm_vec_t nrm
);
  import vna_pkg::*;

  localparam logic [2:0] STEP_LAST = 3'd6;

  vtx_t                     v0_r;
  logic signed [DIFF_W-1:0] ux_r, uy_r, uz_r, wx_r, wy_r, wz_r;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r, acc_r;
  logic signed [NRM_W-1:0]  diff_n;
  logic [2:0]               step_r;
  logic                     run_r;

  // corner minus corner 0, exact
  assign dx = $signed({vdata.x[COORD_WIDTH-1], vdata.x}) - $signed({v0_r.x[COORD_WIDTH-1], v0_r.x});
  assign dy = $signed({vdata.y[COORD_WIDTH-1], vdata.y}) - $signed({v0_r.y[COORD_WIDTH-1], v0_r.y});
  assign dz = $signed({vdata.z[COORD_WIDTH-1], vdata.z}) - $signed({v0_r.z[COORD_WIDTH-1], v0_r.z});

  // product pairs: even step is the minuend, odd step the subtrahend
  always_comb begin
    case (step_r)
      3'd0: begin mul_a = uy_r; mul_b = wz_r; end
      3'd1: begin mul_a = uz_r; mul_b = wy_r; end
      3'd2: begin mul_a = uz_r; mul_b = wx_r; end
      3'd3: begin mul_a = ux_r; mul_b = wz_r; end
      3'd4: begin mul_a = ux_r; mul_b = wy_r; end
      3'd5: begin mul_a = uy_r; mul_b = wx_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign diff_n = $signed({acc_r[PROD_W-1], acc_r}) - $signed({prod_r[PROD_W-1], prod_r});
  assign done   = run_r && (step_r == STEP_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
    end else if (ctl.load_v2) begin
      run_r  <= 1'b1;
      step_r <= '0;
    end else if (run_r) begin
      if (step_r == STEP_LAST) begin
        run_r <= 1'b0;
      end else begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_v0) begin
      v0_r <= vdata;
    end
    if (ctl.load_v1) begin
      ux_r <= dx;
      uy_r <= dy;
      uz_r <= dz;
    end
    if (ctl.load_v2) begin
      wx_r <= dx;
      wy_r <= dy;
      wz_r <= dz;
    end
    if (run_r) begin
      prod_r <= mul_a * mul_b;
      case (step_r) inside
        3'd1, 3'd3, 3'd5: acc_r <= prod_r;
        3'd2:             nrm.x <= diff_n;
        3'd4:             nrm.y <= diff_n;
        3'd6:             nrm.z <= diff_n;
        default: ;
      endcase
    end
  end

endmodule

/* tb/normal_sum_checker.sv */
// checker for the vertex normal accumulator: tracks vertices and sums, compares read words
module normal_sum_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  vna_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  vna_pkg::out_word_t out_data,
  output int                 mismatch_count,
  output int                 pending_reads,
  output int                 reads_checked
);

  import vna_pkg::*;

  localparam longint SUM_HI = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  // shadow copy of the vertex store and the per-vertex sums
  logic signed [COORD_WIDTH-1:0] pos_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] pos_y [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] pos_z [MAX_VERTICES];
  longint                        sum_x [MAX_VERTICES];
  longint                        sum_y [MAX_VERTICES];
  longint                        sum_z [MAX_VERTICES];

  out_word_t normal_fifo [$];

  function automatic longint clamp_add(input longint s, input longint n);
    longint t;
    t = s + n;
    if (t > SUM_HI) return SUM_HI;
    if (t < SUM_LO) return SUM_LO;
    return t;
  endfunction

  // n = (v1 - v0) x (v2 - v0), added to each corner in naming order
  task automatic add_face_normal(input logic [IDX_WIDTH-1:0] a, b, c);
    longint ux, uy, uz, wx, wy, wz, nx, ny, nz;
    logic [IDX_WIDTH-1:0] corner [3];
    ux = longint'(pos_x[b]) - longint'(pos_x[a]);
    uy = longint'(pos_y[b]) - longint'(pos_y[a]);
    uz = longint'(pos_z[b]) - longint'(pos_z[a]);
    wx = longint'(pos_x[c]) - longint'(pos_x[a]);
    wy = longint'(pos_y[c]) - longint'(pos_y[a]);
    wz = longint'(pos_z[c]) - longint'(pos_z[a]);
    nx = uy * wz - uz * wy;
    ny = uz * wx - ux * wz;
    nz = ux * wy - uy * wx;
    corner[0] = a;
    corner[1] = b;
    corner[2] = c;
    for (int k = 0; k < 3; k++) begin
      sum_x[corner[k]] = clamp_add(sum_x[corner[k]], nx);
      sum_y[corner[k]] = clamp_add(sum_y[corner[k]], ny);
      sum_z[corner[k]] = clamp_add(sum_z[corner[k]], nz);
    end
  endtask

  task automatic apply_word(input in_word_t w);
    out_word_t e;
    case (w.op)
      OP_WRITE_VERTEX: begin
        pos_x[w.vertex_index] = w.coord_x;
        pos_y[w.vertex_index] = w.coord_y;
        pos_z[w.vertex_index] = w.coord_z;
        sum_x[w.vertex_index] = 0;
        sum_y[w.vertex_index] = 0;
        sum_z[w.vertex_index] = 0;
      end
      OP_FACE: begin
        add_face_normal(w.corner_a, w.corner_b, w.corner_c);
      end
      OP_READ: begin
        e.normal_x = sum_x[w.vertex_index][SUM_WIDTH-1:0];
        e.normal_y = sum_y[w.vertex_index][SUM_WIDTH-1:0];
        e.normal_z = sum_z[w.vertex_index][SUM_WIDTH-1:0];
        normal_fifo.push_back(e);
      end
      default: begin
        // unused op: no effect
      end
    endcase
  endtask

  task automatic check_normal(input out_word_t act);
    out_word_t e;
    if (normal_fifo.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("unexpected normal word (%0d, %0d, %0d)",
                 act.normal_x, act.normal_y, act.normal_z);
      end
    end else begin
      e = normal_fifo.pop_front();
      reads_checked++;
      if (act.normal_x !== e.normal_x || act.normal_y !== e.normal_y ||
          act.normal_z !== e.normal_z) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("normal word %0d: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                   reads_checked, e.normal_x, e.normal_y, e.normal_z,
                   act.normal_x, act.normal_y, act.normal_z);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      normal_fifo.delete();
      pending_reads  = 0;
      mismatch_count = 0;
      reads_checked  = 0;
    end else begin
      if (out_valid && out_ready) check_normal(out_data);
      if (in_valid && in_ready) apply_word(in_data);
      pending_reads = normal_fifo.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// testbench top: drives vertex, face, read and unused-op words into the normal accumulator
module tb_top;

  import vna_pkg::*;

  localparam int RANDOM_WORDS = 1100;
  localparam int QUIET_LIMIT  = 4000;   // cycles without any handshake
  localparam int TAIL_CYCLES  = 40;     // covers a face still in flight
  localparam int HOT_SPAN     = 48;     // small index window so sums build up
  localparam logic [IDX_WIDTH-1:0] IDX_LAST = IDX_WIDTH'(MAX_VERTICES - 1);

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [COORD_WIDTH-1:0] COORD_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // receiver stall modes
  localparam logic [1:0] RDY_ALWAYS  = 2'd0;
  localparam logic [1:0] RDY_COIN    = 2'd1;
  localparam logic [1:0] RDY_SPARSE  = 2'd2;
  localparam logic [1:0] RDY_PATTERN = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int mismatch_count;
  int pending_reads;
  int reads_checked;

  // stimulus bookkeeping: which vertices hold data, so faces and reads stay legal
  bit          was_written [MAX_VERTICES];
  int unsigned live_idx [$];
  int unsigned hot_idx [$];

  int writes_sent;
  int faces_sent;
  int reads_sent;
  int unused_sent;
  int burst_left;
  int quiet_cycles;

  logic [1:0]  stall_mode = RDY_ALWAYS;
  int          stall_left = 0;
  logic [15:0] stall_pattern = 16'h1;

  vertex_normal_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  normal_sum_checker sum_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_reads  (pending_reads),
    .reads_checked  (reads_checked)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // receiver: each stretch picks a stall mode at random and holds it for a random length
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode    <= 2'($urandom_range(0, 3));
      stall_left    <= $urandom_range(20, 200);
      stall_pattern <= 16'($urandom) | 16'h1;   // never all-stall
    end else begin
      stall_left <= stall_left - 1;
      if (stall_mode == RDY_PATTERN) begin
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
    end
    case (stall_mode)
      RDY_ALWAYS:  out_ready <= 1'b1;
      RDY_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
      default:     out_ready <= stall_pattern[0];
    endcase
  end

  // watchdog: ends the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // every word starts fully random so unused fields toggle too
  function automatic in_word_t rand_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return in_word_t'(raw[$bits(in_word_t)-1:0]);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(0, 5)) inside
      0:       return COORD_HI;
      1:       return COORD_LO;
      2, 3:    return COORD_WIDTH'(int'($urandom_range(0, 511)) - 256);
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  // mostly the hot window, sometimes anywhere that has been written
  function automatic logic [IDX_WIDTH-1:0] pick_live();
    if (hot_idx.size() != 0 && $urandom_range(0, 3) != 0) begin
      return IDX_WIDTH'(hot_idx[$urandom_range(0, hot_idx.size() - 1)]);
    end
    return IDX_WIDTH'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
  endfunction

  // caller sits at a falling edge; returns at a falling edge after acceptance
  task automatic push_word(input in_word_t w);
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    case (w.op)
      OP_WRITE_VERTEX: writes_sent++;
      OP_FACE:         faces_sent++;
      OP_READ:         reads_sent++;
      default:         unused_sent++;
    endcase
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      // end of burst: drop valid for a short gap, now and then a long one
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 6)) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic send_write(input logic [IDX_WIDTH-1:0] idx,
                            input logic signed [COORD_WIDTH-1:0] x, y, z);
    in_word_t w;
    w              = rand_word();
    w.op           = OP_WRITE_VERTEX;
    w.vertex_index = idx;
    w.coord_x      = x;
    w.coord_y      = y;
    w.coord_z      = z;
    if (!was_written[idx]) begin
      was_written[idx] = 1'b1;
      live_idx.push_back(idx);
      if (idx < HOT_SPAN) hot_idx.push_back(idx);
    end
    push_word(w);
  endtask

  task automatic send_face(input logic [IDX_WIDTH-1:0] a, b, c);
    in_word_t w;
    w          = rand_word();
    w.op       = OP_FACE;
    w.corner_a = a;
    w.corner_b = b;
    w.corner_c = c;
    push_word(w);
  endtask

  task automatic send_read(input logic [IDX_WIDTH-1:0] idx);
    in_word_t w;
    w              = rand_word();
    w.op           = OP_READ;
    w.vertex_index = idx;
    push_word(w);
  endtask

  task automatic send_unused();
    in_word_t w;
    w    = rand_word();
    w.op = OP_UNUSED;
    push_word(w);
  endtask

  // hold off the sender until every read word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_reads != 0);
  endtask

  initial begin
    logic [IDX_WIDTH-1:0] a, b, c;
    int sel;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: coordinate and index extremes, fresh sums, repeated corners,
    // unused op, and a rewrite that must clear accumulated sums
    send_write(0, COORD_LO, COORD_LO, COORD_LO);
    send_write(1, COORD_HI, COORD_LO, 0);
    send_write(2, COORD_LO, COORD_HI, COORD_HI);
    send_write(IDX_LAST, COORD_HI, COORD_HI, COORD_HI);
    send_write(512, 1, -1, 12345);
    send_read(0);
    send_face(0, 1, 2);
    send_face(IDX_LAST, 2, 1);
    send_face(0, 0, 1);
    send_face(2, 2, 2);
    send_face(IDX_LAST, 512, 0);
    send_unused();
    send_read(0);
    send_read(1);
    send_read(2);
    send_read(IDX_LAST);
    send_read(512);
    send_write(1, -7, COORD_HI, COORD_LO);
    send_read(1);
    send_face(1, IDX_LAST, 0);
    send_read(1);
    send_read(IDX_LAST);
    send_unused();
    wait_drained();

    // random: mostly faces over a small hot set so sums grow large,
    // with vertex rewrites, reads and a little unused-op noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        a = ($urandom_range(0, 2) != 0) ? IDX_WIDTH'($urandom_range(0, HOT_SPAN - 1))
                                        : IDX_WIDTH'($urandom_range(0, IDX_LAST));
        send_write(a, pick_coord(), pick_coord(), pick_coord());
      end else if (sel < 68) begin
        a = pick_live();
        b = pick_live();
        c = pick_live();
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) != 0) b = a;
          else c = b;
        end
        send_face(a, b, c);
      end else if (sel < 97) begin
        send_read(pick_live());
      end else begin
        send_unused();
      end
      if (n % 250 == 249) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d vertex writes, %0d faces, %0d reads, %0d unused-op words",
             writes_sent, faces_sent, reads_sent, unused_sent);
    $display("%0d normal words checked, %0d mismatches, %0d still outstanding",
             reads_checked, mismatch_count, pending_reads);
    if (mismatch_count == 0 && pending_reads == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
